// ===== design/whmm_pkg.sv =====
package whmm_pkg;

  localparam int QueueDepth = 2;

  localparam logic [31:0] MixMult = 32'h5bd1e995;
  localparam int WordShift = 24;
  localparam int FinalShiftA = 13;
  localparam int FinalShiftB = 15;

  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharLf = 8'h0a;
  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic CfgSeed = 1'b0;
  localparam logic CfgSkip = 1'b1;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_COUNT  = 3'd1,
    OP_BEGIN  = 3'd2,
    OP_HASH   = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/whmm_front.sv =====
module whmm_front (
  input  logic                 in_valid,
  input  logic [2:0]           operation,
  input  logic [7:0]           data_byte,
  input  logic                 skip_whitespace,
  input  whmm_pkg::q_status_t  q_status,
  output logic                 in_stall,
  output logic                 push,
  output whmm_pkg::cmd_t       push_cmd
);
  import whmm_pkg::*;

  logic blank;
  logic useful;

  assign blank = skip_whitespace &&
                 (data_byte == CharTab || data_byte == CharLf ||
                  data_byte == CharCr || data_byte == CharSpace);

  // drop skipped bytes and unused codes here so the back end never sees them
  always_comb begin
    unique case (operation)
      OP_START, OP_BEGIN, OP_FINISH: useful = 1'b1;
      OP_COUNT, OP_HASH:             useful = !blank;
      default:                       useful = 1'b0;
    endcase
  end

  assign in_stall      = q_status.full;
  assign push          = in_valid && !q_status.full && useful;
  assign push_cmd.op   = op_t'(operation);
  assign push_cmd.data = data_byte;

endmodule

// ===== design/whmm_queue.sv =====
module whmm_queue #(
  parameter int DEPTH = whmm_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  whmm_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output whmm_pkg::cmd_t       pop_cmd,
  output whmm_pkg::q_status_t  q_status
);
  import whmm_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign q_status.full  = (fill == CntW'(DEPTH));
  assign q_status.empty = (fill == '0);
  assign pop_cmd        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

// ===== design/whmm_back.sv =====
module whmm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  whmm_pkg::cmd_t       cmd,
  input  logic [31:0]          seed,
  input  logic                 out_stall,
  output logic                 pop,
  output logic                 out_valid,
  output logic [31:0]          hash_value
);
  import whmm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MIX_A = 5'b00010,
    ST_MIX_B = 5'b00100,
    ST_FIN_A = 5'b01000,
    ST_FIN_B = 5'b10000
  } state_t;

  state_t      state;
  logic [31:0] kept_count;
  logic [31:0] word_acc;
  logic [1:0]  byte_pos;
  logic [31:0] running_hash;
  logic [31:0] scratch;

  logic [31:0] lane_word;
  logic [31:0] full_word;
  logic [31:0] mul_operand;
  logic [31:0] product;

  assign lane_word = {24'b0, cmd.data} << {byte_pos, 3'b000};
  assign full_word = word_acc | lane_word;

  // one shared multiplier, operand picked by the sequencer step
  always_comb begin
    unique case (state)
      ST_MIX_A: mul_operand = scratch ^ (scratch >> WordShift);
      ST_MIX_B: mul_operand = running_hash;
      ST_FIN_A: mul_operand = scratch ^ (scratch >> FinalShiftA);
      default:  mul_operand = (cmd.op == OP_FINISH) ? (running_hash ^ word_acc) : full_word;
    endcase
  end

  assign product = mul_operand * MixMult;
  assign pop     = (state == ST_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      kept_count   <= '0;
      word_acc     <= '0;
      byte_pos     <= '0;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_FIN_B && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_START: begin
                kept_count <= '0;
                word_acc   <= '0;
                byte_pos   <= '0;
              end
              OP_COUNT: kept_count <= kept_count + 32'd1;
              OP_BEGIN: running_hash <= seed ^ kept_count;
              OP_HASH: begin
                if (byte_pos == 2'd3) begin
                  scratch  <= product;
                  word_acc <= '0;
                  byte_pos <= '0;
                  state    <= ST_MIX_A;
                end else begin
                  word_acc <= full_word;
                  byte_pos <= byte_pos + 2'd1;
                end
              end
              OP_FINISH: begin
                // fold a partial word only when one is pending
                scratch <= (byte_pos != 2'd0) ? product : running_hash;
                state   <= ST_FIN_A;
              end
              default: ;
            endcase
          end
        end
        ST_MIX_A: begin
          scratch <= product;
          state   <= ST_MIX_B;
        end
        ST_MIX_B: begin
          running_hash <= product ^ scratch;
          state        <= ST_IDLE;
        end
        ST_FIN_A: begin
          scratch <= product;
          state   <= ST_FIN_B;
        end
        ST_FIN_B: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            hash_value <= scratch ^ (scratch >> FinalShiftB);
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/whitespace_skipping_murmur2_hash.sv =====
// Start, count, begin and partial-lane hash items take effect when popped from the queue;
// a hash item that completes a word then runs ST_MIX_A and ST_MIX_B, and a finish runs
// ST_FIN_A and ST_FIN_B, using one shared 32x32 multiplier in turn, before registering
// its result. Throughput: one item per cycle while the back end is idle and the queue
// is not full; mixes and finishes keep it busy, and a finish also waits on out_stall.
// Reset (rst, synchronous): back end idle, running hash zero, seed to 1, skipping on.
module whitespace_skipping_murmur2_hash #(
  parameter int QUEUE_DEPTH = whmm_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import whmm_pkg::*;

  logic        seed_reg_valid_unused;
  logic [31:0] seed;
  logic        skip_whitespace;

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      pop_cmd;
  q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign seed_reg_valid_unused = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed            <= 32'd1;
      skip_whitespace <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgSeed: seed            <= cfg_data;
        CfgSkip: skip_whitespace <= cfg_data[0];
        default: ;
      endcase
    end
  end

  whmm_front u_front (
    .in_valid        (in_valid),
    .operation       (operation),
    .data_byte       (data_byte),
    .skip_whitespace (skip_whitespace),
    .q_status        (q_status),
    .in_stall        (in_stall),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  whmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  whmm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!q_status.empty && !seed_reg_valid_unused),
    .cmd        (pop_cmd),
    .seed       (seed),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .hash_value (hash_value)
  );

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("push into full queue");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !in_stall)
    else $error("input stalled with empty queue");
`endif

endmodule
